### rtl/assert_macros.svh
// assertion macros shared by the list engine modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CLE_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// when trig holds, cons must hold at the next clock edge
`define CLE_ASSERT_NEXT(lbl, clk, rst, trig, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

### rtl/cle_pkg.sv
// shared types and constants for the cursor list engine
package cle_pkg;

   localparam int CAP_DEFAULT        = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef enum logic [3:0] {
      FN_INSERT = 4'd0,
      FN_APPEND = 4'd1,
      FN_ERASE  = 4'd2,
      FN_BEGIN  = 4'd3,
      FN_END    = 4'd4,
      FN_PREV   = 4'd5,
      FN_NEXT   = 4'd6,
      FN_TO_POS = 4'd7,
      FN_FIND   = 4'd8,
      FN_CLEAR  = 4'd9
   } func_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_APPLY,
      CMD_INS_INIT,
      CMD_RD_PREV,
      CMD_WR_DN,
      CMD_INS_FIN,
      CMD_ERA_INIT,
      CMD_ERA_CAP,
      CMD_RD_NEXT,
      CMD_WR_UP,
      CMD_ERA_FIN,
      CMD_FIND_INIT,
      CMD_RD_IDX,
      CMD_FIND_CMP,
      CMD_RD_CUR
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_CHK,
      ST_INS_WR,
      ST_ERA_CAP,
      ST_ERA_CHK,
      ST_ERA_WR,
      ST_FIND_CHK,
      ST_FIND_CMP,
      ST_RD_CUR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [3:0] func;
      logic       full;
      logic       empty;
      logic       idx_gt_cur;
      logic       idx_nxt_lt_cnt;
      logic       idx_lt_cnt;
      logic       found;
   } status_type;

endpackage

### rtl/cle_dpath.sv
// list storage, count and cursor registers, walk index and result registers
`include "assert_macros.svh"

module cle_dpath #(
   parameter int CAP        = cle_pkg::CAP_DEFAULT,
   parameter int DATA_WIDTH = cle_pkg::DATA_WIDTH_DEFAULT,
   parameter int CNT_W      = $clog2(CAP + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cle_pkg::cmd_type      cmd,
   input  logic                  out_load,
   output cle_pkg::status_type   status,
   input  logic [3:0]            req_func,
   input  logic [DATA_WIDTH-1:0] req_value,
   input  logic [CNT_W-1:0]      req_pos,
   output logic [DATA_WIDTH-1:0] rsp_item_value,
   output logic [CNT_W-1:0]      rsp_find_index,
   output logic [CNT_W-1:0]      rsp_cursor_pos,
   output logic [CNT_W-1:0]      rsp_list_size,
   output logic                  rsp_error
);

   localparam int AW = (CAP > 1) ? $clog2(CAP) : 1;

   logic [DATA_WIDTH-1:0] mem [CAP];

   logic [3:0]            func_ff, func_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      cursor_ff, cursor_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic                  err_ff, err_in;
   logic                  erased_ff, erased_in;
   logic [DATA_WIDTH-1:0] erased_val_ff, erased_val_in;
   logic [CNT_W-1:0]      find_ff, find_in;
   logic                  found_ff, found_in;

   logic [DATA_WIDTH-1:0] out_item_ff;
   logic [CNT_W-1:0]      out_find_ff;
   logic [CNT_W-1:0]      out_cursor_ff;
   logic [CNT_W-1:0]      out_size_ff;
   logic                  out_err_ff;

   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [CNT_W-1:0]      idx_nxt;
   logic [CNT_W-1:0]      idx_prv;
   logic [CNT_W-1:0]      erase_base;

   assign idx_nxt    = idx_ff + CNT_W'(1);
   assign idx_prv    = idx_ff - CNT_W'(1);
   // erase while past the end takes the head
   assign erase_base = (cursor_ff >= count_ff) ? '0 : cursor_ff;

   always_comb begin
      func_in       = func_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      idx_in        = idx_ff;
      err_in        = err_ff;
      erased_in     = erased_ff;
      erased_val_in = erased_val_ff;
      find_in       = find_ff;
      found_in      = found_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = rdata_ff;
      unique case (cmd)
         cle_pkg::CMD_LOAD: begin
            func_in   = req_func;
            value_in  = req_value;
            pos_in    = req_pos;
            err_in    = 1'b0;
            erased_in = 1'b0;
            find_in   = '1;
            found_in  = 1'b0;
         end
         cle_pkg::CMD_APPLY: begin
            case (func_ff)
               cle_pkg::FN_INSERT: err_in = 1'b1;
               cle_pkg::FN_ERASE:  err_in = 1'b1;
               cle_pkg::FN_APPEND: begin
                  if (count_ff == CNT_W'(CAP)) begin
                     err_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     wr_data  = value_ff;
                     count_in = count_ff + CNT_W'(1);
                     if (cursor_ff == count_ff) begin
                        cursor_in = count_ff + CNT_W'(1);
                     end
                  end
               end
               cle_pkg::FN_BEGIN: cursor_in = '0;
               cle_pkg::FN_END: begin
                  cursor_in = (count_ff != '0) ? count_ff - CNT_W'(1) : '0;
               end
               cle_pkg::FN_PREV: begin
                  if (cursor_ff != '0) begin
                     cursor_in = cursor_ff - CNT_W'(1);
                  end
               end
               cle_pkg::FN_NEXT: begin
                  if (count_ff != '0 && cursor_ff < count_ff - CNT_W'(1)) begin
                     cursor_in = cursor_ff + CNT_W'(1);
                  end
               end
               cle_pkg::FN_TO_POS: begin
                  if (pos_ff > count_ff) begin
                     err_in = 1'b1;
                  end else begin
                     cursor_in = pos_ff;
                  end
               end
               cle_pkg::FN_CLEAR: begin
                  count_in  = '0;
                  cursor_in = '0;
               end
               default: ;
            endcase
         end
         cle_pkg::CMD_INS_INIT: idx_in = count_ff;
         cle_pkg::CMD_RD_PREV: begin
            rd_en   = 1'b1;
            rd_addr = idx_prv[AW-1:0];
         end
         cle_pkg::CMD_WR_DN: begin
            wr_en  = 1'b1;
            idx_in = idx_prv;
         end
         cle_pkg::CMD_INS_FIN: begin
            wr_en    = 1'b1;
            wr_addr  = cursor_ff[AW-1:0];
            wr_data  = value_ff;
            count_in = count_ff + CNT_W'(1);
         end
         cle_pkg::CMD_ERA_INIT: begin
            rd_en     = 1'b1;
            rd_addr   = erase_base[AW-1:0];
            idx_in    = erase_base;
            cursor_in = erase_base;
         end
         cle_pkg::CMD_ERA_CAP: begin
            erased_in     = 1'b1;
            erased_val_in = rdata_ff;
         end
         cle_pkg::CMD_RD_NEXT: begin
            rd_en   = 1'b1;
            rd_addr = idx_nxt[AW-1:0];
         end
         cle_pkg::CMD_WR_UP: begin
            wr_en  = 1'b1;
            idx_in = idx_nxt;
         end
         cle_pkg::CMD_ERA_FIN: count_in = count_ff - CNT_W'(1);
         cle_pkg::CMD_FIND_INIT: idx_in = '0;
         cle_pkg::CMD_RD_IDX: rd_en = 1'b1;
         cle_pkg::CMD_FIND_CMP: begin
            if (rdata_ff == value_ff) begin
               found_in = 1'b1;
               find_in  = idx_ff;
            end
            idx_in = idx_nxt;
         end
         cle_pkg::CMD_RD_CUR: begin
            rd_en   = 1'b1;
            rd_addr = cursor_ff[AW-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      err_ff        <= err_in;
      erased_ff     <= erased_in;
      erased_val_ff <= erased_val_in;
      find_ff       <= find_in;
      found_ff      <= found_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // result beat registers, loaded once the output side is free
   always_ff @(posedge clock) begin
      if (out_load) begin
         if (erased_ff) begin
            out_item_ff <= erased_val_ff;
         end else if (cursor_ff < count_ff) begin
            out_item_ff <= rdata_ff;
         end else begin
            out_item_ff <= '0;
         end
         out_find_ff   <= find_ff;
         out_cursor_ff <= cursor_ff;
         out_size_ff   <= count_ff;
         out_err_ff    <= err_ff;
      end
   end

   assign rsp_item_value = out_item_ff;
   assign rsp_find_index = out_find_ff;
   assign rsp_cursor_pos = out_cursor_ff;
   assign rsp_list_size  = out_size_ff;
   assign rsp_error      = out_err_ff;

   assign status.func           = func_ff;
   assign status.full           = (count_ff == CNT_W'(CAP));
   assign status.empty          = (count_ff == '0);
   assign status.idx_gt_cur     = (idx_ff > cursor_ff);
   assign status.idx_nxt_lt_cnt = (idx_nxt < count_ff);
   assign status.idx_lt_cnt     = (idx_ff < count_ff);
   assign status.found          = found_ff;

   `CLE_ASSERT_ALWAYS(a_count_cap, clock, reset, count_ff <= CNT_W'(CAP), "count above capacity")
   `CLE_ASSERT_ALWAYS(a_cursor_le_count, clock, reset, cursor_ff <= count_ff, "cursor beyond size")
   `CLE_ASSERT_ALWAYS(a_shift_in_range, clock, reset, !(cmd == cle_pkg::CMD_WR_DN) || idx_ff > cursor_ff, "insert shift below cursor")

endmodule

### rtl/cle_ctrl.sv
// sequencer for the list operations and the result beat valid
`include "assert_macros.svh"

module cle_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  cle_pkg::status_type status,
   output cle_pkg::cmd_type    cmd,
   output logic                out_load
);

   cle_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != cle_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cle_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = cle_pkg::CMD_NONE;
      out_load = 1'b0;
      unique case (state_ff)
         cle_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd      = cle_pkg::CMD_LOAD;
               state_in = cle_pkg::ST_DISPATCH;
            end
         end
         cle_pkg::ST_DISPATCH: begin
            case (status.func)
               cle_pkg::FN_INSERT: begin
                  if (status.full) begin
                     cmd      = cle_pkg::CMD_APPLY;
                     state_in = cle_pkg::ST_RD_CUR;
                  end else begin
                     cmd      = cle_pkg::CMD_INS_INIT;
                     state_in = cle_pkg::ST_INS_CHK;
                  end
               end
               cle_pkg::FN_ERASE: begin
                  if (status.empty) begin
                     cmd      = cle_pkg::CMD_APPLY;
                     state_in = cle_pkg::ST_RD_CUR;
                  end else begin
                     cmd      = cle_pkg::CMD_ERA_INIT;
                     state_in = cle_pkg::ST_ERA_CAP;
                  end
               end
               cle_pkg::FN_FIND: begin
                  cmd      = cle_pkg::CMD_FIND_INIT;
                  state_in = cle_pkg::ST_FIND_CHK;
               end
               default: begin
                  cmd      = cle_pkg::CMD_APPLY;
                  state_in = cle_pkg::ST_RD_CUR;
               end
            endcase
         end
         cle_pkg::ST_INS_CHK: begin
            if (status.idx_gt_cur) begin
               cmd      = cle_pkg::CMD_RD_PREV;
               state_in = cle_pkg::ST_INS_WR;
            end else begin
               cmd      = cle_pkg::CMD_INS_FIN;
               state_in = cle_pkg::ST_RD_CUR;
            end
         end
         cle_pkg::ST_INS_WR: begin
            cmd      = cle_pkg::CMD_WR_DN;
            state_in = cle_pkg::ST_INS_CHK;
         end
         cle_pkg::ST_ERA_CAP: begin
            cmd      = cle_pkg::CMD_ERA_CAP;
            state_in = cle_pkg::ST_ERA_CHK;
         end
         cle_pkg::ST_ERA_CHK: begin
            if (status.idx_nxt_lt_cnt) begin
               cmd      = cle_pkg::CMD_RD_NEXT;
               state_in = cle_pkg::ST_ERA_WR;
            end else begin
               cmd      = cle_pkg::CMD_ERA_FIN;
               state_in = cle_pkg::ST_RD_CUR;
            end
         end
         cle_pkg::ST_ERA_WR: begin
            cmd      = cle_pkg::CMD_WR_UP;
            state_in = cle_pkg::ST_ERA_CHK;
         end
         cle_pkg::ST_FIND_CHK: begin
            if (status.idx_lt_cnt && !status.found) begin
               cmd      = cle_pkg::CMD_RD_IDX;
               state_in = cle_pkg::ST_FIND_CMP;
            end else begin
               state_in = cle_pkg::ST_RD_CUR;
            end
         end
         cle_pkg::ST_FIND_CMP: begin
            cmd      = cle_pkg::CMD_FIND_CMP;
            state_in = cle_pkg::ST_FIND_CHK;
         end
         cle_pkg::ST_RD_CUR: begin
            cmd      = cle_pkg::CMD_RD_CUR;
            state_in = cle_pkg::ST_OUT;
         end
         cle_pkg::ST_OUT: begin
            // wait here until the previous result beat is taken
            if (out_free) begin
               out_load = 1'b1;
               state_in = cle_pkg::ST_IDLE;
            end
         end
         default: state_in = cle_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   `CLE_ASSERT_NEXT(a_accept_dispatch, clock, reset, req_valid && !req_stall, state_ff == cle_pkg::ST_DISPATCH, "accepted beat not dispatched")
   `CLE_ASSERT_NEXT(a_load_valid, clock, reset, out_load, rsp_valid_ff, "loaded result not presented")
   `CLE_ASSERT_ALWAYS(a_load_free, clock, reset, !out_load || out_free, "result overwritten while stalled")

endmodule

### rtl/cursor_list_engine_unit.sv
// cursor list engine: top level joining the sequencer and the list datapath
//
// Ordered list of up to CAP values with a cursor. One request beat on the
// req_ channel (func, value, pos) gives exactly one response beat on the
// rsp_ channel (item value, find index or all ones, cursor, size, error).
// A beat moves when valid is high and stall is low at a rising edge.
// Work after acceptance, n the list size, c the cursor; each operation
// ends with a read at the cursor before the result is loaded:
//   insert shifts n-c elements up, erase shifts the elements behind c down
//   (c is 0 past the end), find compares at most n elements, up to a match.
// The storage has one read and one write port, and each shifted or compared
// element takes a registered read and then a write or compare.
// One request is worked on at a time; req_stall is high from acceptance
// until the result is placed in the output register, which holds it while
// rsp_stall is high so the next request may already be accepted. req_stall
// falls in the same cycle as rsp_valid rises, so a new request is taken at the earliest while rsp_valid is first high.
// Reset (synchronous) empties the list, puts the cursor at 0 and drops
// rsp_valid; stored values need no clearing.
module cursor_list_engine_unit #(
   parameter int CAP        = cle_pkg::CAP_DEFAULT,
   parameter int DATA_WIDTH = cle_pkg::DATA_WIDTH_DEFAULT,
   parameter int CNT_W      = $clog2(CAP + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [3:0]            req_func,
   input  logic [DATA_WIDTH-1:0] req_value,
   input  logic [CNT_W-1:0]      req_pos,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0] rsp_item_value,
   output logic [CNT_W-1:0]      rsp_find_index,
   output logic [CNT_W-1:0]      rsp_cursor_pos,
   output logic [CNT_W-1:0]      rsp_list_size,
   output logic                  rsp_error
);

   cle_pkg::cmd_type    cmd;
   cle_pkg::status_type status;
   logic                out_load;

   cle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .out_load  (out_load)
   );

   cle_dpath #(
      .CAP        (CAP),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .out_load       (out_load),
      .status         (status),
      .req_func       (req_func),
      .req_value      (req_value),
      .req_pos        (req_pos),
      .rsp_item_value (rsp_item_value),
      .rsp_find_index (rsp_find_index),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_list_size  (rsp_list_size),
      .rsp_error      (rsp_error)
   );

endmodule
